// ----- rtl/quaternion_to_rotation_matrix_defines.svh -----
// Assertion macros shared by the quaternion-to-matrix RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, held off during reset
`define QRM_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("qrm check failed");

// Next-cycle implication, held off during reset
`define QRM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("qrm check failed");

`else

`define QRM_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define QRM_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ----- rtl/qrm_pkg.sv -----
// Types, constants and helper functions for the quaternion-to-matrix pipeline.
// No dependencies; imported by every module of the block.
package qrm_pkg;

  localparam int FW = 16;          // field width, Q2.14
  localparam int PW = 2 * FW;      // signed product width
  localparam int NP = 10;          // products formed per item
  localparam int NT = 9;           // product terms divided by the norm
  localparam int NW = 2 * FW + 1;  // squared norm width
  localparam int RW = 2 * FW;      // divider remainder width (rem < norm)
  localparam int QW = FW;          // quotient magnitude width, up to 32768
  localparam int SW = FW + 3;      // width of a combined matrix entry

  localparam logic signed [SW-1:0] Q_ONE = SW'(16384);
  localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);
  localparam logic [QW-1:0] HALF_SCALE = QW'(16384);

  // product slots
  localparam int PXX = 0;
  localparam int PYY = 1;
  localparam int PZZ = 2;
  localparam int PWW = 3;

  // divider lanes: three squares, then six cross terms
  localparam int TXX = 0;
  localparam int TYY = 1;
  localparam int TZZ = 2;
  localparam int TXY = 3;
  localparam int TXZ = 4;
  localparam int TYZ = 5;
  localparam int TWX = 6;
  localparam int TWY = 7;
  localparam int TWZ = 8;

  typedef struct packed {
    logic signed [FW-1:0] quat_x;
    logic signed [FW-1:0] quat_y;
    logic signed [FW-1:0] quat_z;
    logic signed [FW-1:0] quat_w;
    logic signed [FW-1:0] shift_x;
    logic signed [FW-1:0] shift_y;
  } qrm_in_t;

  typedef struct packed {
    logic signed [FW-1:0] rot_00;
    logic signed [FW-1:0] rot_01;
    logic signed [FW-1:0] rot_02;
    logic signed [FW-1:0] rot_10;
    logic signed [FW-1:0] rot_11;
    logic signed [FW-1:0] rot_12;
    logic signed [FW-1:0] rot_20;
    logic signed [FW-1:0] rot_21;
    logic signed [FW-1:0] rot_22;
    logic signed [FW-1:0] trans_x;
    logic signed [FW-1:0] trans_y;
  } qrm_out_t;

  // registered products, first stage
  typedef struct packed {
    logic [NP-1:0][PW-1:0] prod;
    logic [FW-1:0]         tx;
    logic [FW-1:0]         ty;
  } qrm_prod_t;

  // one divider lane: partial remainder, quotient bits so far, sign of term
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] quo;
    logic          neg;
  } qrm_lane_t;

  // payload that travels through the divider stages
  typedef struct packed {
    qrm_lane_t [NT-1:0] lane;
    logic [NW-1:0]      norm;
    logic               zero;
    logic [FW-1:0]      tx;
    logic [FW-1:0]      ty;
  } qrm_div_t;

  // Map a divider lane to its product slot (ww is skipped)
  function automatic int qrm_lane_prod(input int lane);
    return (lane < PWW) ? lane : lane + 1;
  endfunction

  // One restoring-division step on every lane. The first step compares the
  // undoubled remainder so that a quotient of exactly 2^15 comes out right.
  function automatic qrm_div_t qrm_div_step(input qrm_div_t d, input logic first);
    qrm_div_t      r;
    logic [RW:0]   t;
    logic          take;
    r = d;
    for (int i = 0; i < NT; i++) begin
      t    = first ? {1'b0, d.lane[i].rem} : {d.lane[i].rem, 1'b0};
      take = (t >= d.norm);
      r.lane[i].quo = {d.lane[i].quo[QW-2:0], take};
      r.lane[i].rem = take ? RW'(t - d.norm) : t[RW-1:0];
    end
    return r;
  endfunction

  // Signed term from a lane; a zero norm forces every term to zero
  function automatic logic signed [SW-1:0] qrm_term(input qrm_lane_t l, input logic zero);
    logic signed [SW-1:0] mag;
    mag = $signed({{(SW-QW){1'b0}}, l.quo});
    if (zero) begin
      return '0;
    end
    return l.neg ? -mag : mag;
  endfunction

  // Clamp a combined entry to the 16-bit signed range
  function automatic logic [FW-1:0] qrm_sat(input logic signed [SW-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[FW-1:0];
    end
    if (v < SAT_LO) begin
      return SAT_LO[FW-1:0];
    end
    return v[FW-1:0];
  endfunction

endpackage

// ----- rtl/quaternion_to_rotation_matrix.sv -----
// Quaternion to 3x3 rotation matrix with translation column; top level.
// Depends on qrm_pkg, qrm_norm, qrm_divider and qrm_combine.
//
// Takes one quaternion (Q2.14, any length) and an x/y shift per transfer and
// returns the rotation matrix entries 2ab/n style, each term truncated toward
// zero, combined and saturated to Q2.14, plus the shift passed through. A zero
// quaternion gives the identity. The block is fully pipelined: one transfer
// per cycle in and out while not back-pressured, through the product and norm
// registers, sixteen one-bit restoring divider stages and one output register.
// The divider depth, one stage per quotient bit, sets the latency. Backpressure
// holds the data in place without losing any; empty stages still fill.
module quaternion_to_rotation_matrix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qrm_pkg::qrm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qrm_pkg::qrm_out_t out_data
);
  import qrm_pkg::*;

  logic     nrm_valid, nrm_ready;
  qrm_div_t nrm_data;
  logic     div_valid, div_ready;
  qrm_div_t div_data;

  // products and squared norm
  qrm_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (nrm_valid),
    .out_ready (nrm_ready),
    .out_data  (nrm_data)
  );

  // nine-lane pipelined divider
  qrm_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nrm_valid),
    .in_ready  (nrm_ready),
    .in_data   (nrm_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // matrix assembly and output register
  qrm_combine u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/qrm_norm.sv -----
// Front end: multiplies the quaternion components pairwise, then forms the
// squared norm and term magnitudes. Two register stages. Uses qrm_pkg.
module qrm_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qrm_pkg::qrm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qrm_pkg::qrm_div_t out_data
);
  import qrm_pkg::*;

  logic      v0_r, v1_r;
  logic      adv0, adv1;
  qrm_prod_t p_r, p_nxt;
  qrm_div_t  d_r, d_nxt;

  // stall chain
  assign adv1     = !v1_r || out_ready;
  assign adv0     = !v0_r || adv1;
  assign in_ready = adv0;

  // stage 0: ten signed 16x16 products
  always_comb begin
    p_nxt.prod[PXX] = PW'(in_data.quat_x * in_data.quat_x);
    p_nxt.prod[PYY] = PW'(in_data.quat_y * in_data.quat_y);
    p_nxt.prod[PZZ] = PW'(in_data.quat_z * in_data.quat_z);
    p_nxt.prod[PWW] = PW'(in_data.quat_w * in_data.quat_w);
    p_nxt.prod[qrm_lane_prod(TXY)] = PW'(in_data.quat_x * in_data.quat_y);
    p_nxt.prod[qrm_lane_prod(TXZ)] = PW'(in_data.quat_x * in_data.quat_z);
    p_nxt.prod[qrm_lane_prod(TYZ)] = PW'(in_data.quat_y * in_data.quat_z);
    p_nxt.prod[qrm_lane_prod(TWX)] = PW'(in_data.quat_w * in_data.quat_x);
    p_nxt.prod[qrm_lane_prod(TWY)] = PW'(in_data.quat_w * in_data.quat_y);
    p_nxt.prod[qrm_lane_prod(TWZ)] = PW'(in_data.quat_w * in_data.quat_z);
    p_nxt.tx = in_data.shift_x;
    p_nxt.ty = in_data.shift_y;
  end

  // stage 1: norm sum, magnitudes and signs
  always_comb begin
    logic [PW-1:0] p;
    d_nxt.norm = NW'(p_r.prod[PXX]) + NW'(p_r.prod[PYY])
               + NW'(p_r.prod[PZZ]) + NW'(p_r.prod[PWW]);
    d_nxt.zero = (d_nxt.norm == '0);
    for (int i = 0; i < NT; i++) begin
      p = p_r.prod[qrm_lane_prod(i)];
      d_nxt.lane[i].neg = p[PW-1];
      d_nxt.lane[i].rem = p[PW-1] ? RW'(-p) : p;
      d_nxt.lane[i].quo = '0;
    end
    d_nxt.tx = p_r.tx;
    d_nxt.ty = p_r.ty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (adv0) begin
        v0_r <= in_valid;
      end
      if (adv1) begin
        v1_r <= v0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_valid) begin
      p_r <= p_nxt;
    end
    if (adv1 && v0_r) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v1_r;
  assign out_data  = d_r;

endmodule

// ----- rtl/qrm_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage on nine lanes that
// share the squared norm as divisor. Uses qrm_pkg and the assertion macros.
`include "quaternion_to_rotation_matrix_defines.svh"
module qrm_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qrm_pkg::qrm_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qrm_pkg::qrm_div_t out_data
);
  import qrm_pkg::*;

  logic [QW-1:0] v_r;
  logic [QW-1:0] adv;
  qrm_div_t      st_r [QW];

  // stall chain, last stage first
  assign adv[QW-1] = !v_r[QW-1] || out_ready;
  for (genvar k = 0; k < QW - 1; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  // stage k resolves quotient bit QW-1-k
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic     vin;
    qrm_div_t din;
    qrm_div_t st_nxt;
    if (k == 0) begin : g_first
      assign vin    = in_valid;
      assign din    = in_data;
      assign st_nxt = qrm_div_step(din, 1'b1);
    end else begin : g_rest
      assign vin    = v_r[k-1];
      assign din    = st_r[k-1];
      assign st_nxt = qrm_div_step(din, 1'b0);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && vin) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_data  = st_r[QW-1];

  // finished remainders are below the divisor
  `QRM_ASSERT_IMPL(a_rem_below_norm, clk, rst_n, out_valid && !out_data.zero, out_data.lane[TXY].rem < out_data.norm && out_data.lane[TXX].rem < out_data.norm)
  // a stalled result at the divider tail stays put
  `QRM_ASSERT_NEXT(a_tail_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // the divider refuses input only when it is full and its tail is stalled
  `QRM_ASSERT_IMPL(a_full_means_stall, clk, rst_n, !in_ready, (&v_r) && !out_ready)

endmodule

// ----- rtl/qrm_combine.sv -----
// Back end: signs the quotients, assembles the nine matrix entries with
// saturation and holds them in the output register. Uses qrm_pkg and macros.
`include "quaternion_to_rotation_matrix_defines.svh"
module qrm_combine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qrm_pkg::qrm_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qrm_pkg::qrm_out_t out_data
);
  import qrm_pkg::*;

  logic                 out_valid_r;
  qrm_out_t             out_data_r, out_data_nxt;
  logic signed [SW-1:0] t [NT];

  assign in_ready = !out_valid_r || out_ready;

  // signed terms
  for (genvar i = 0; i < NT; i++) begin : g_term
    assign t[i] = qrm_term(in_data.lane[i], in_data.zero);
  end

  // matrix assembly
  always_comb begin
    out_data_nxt.rot_00  = qrm_sat(Q_ONE - (t[TYY] + t[TZZ]));
    out_data_nxt.rot_01  = qrm_sat(t[TXY] - t[TWZ]);
    out_data_nxt.rot_02  = qrm_sat(t[TXZ] + t[TWY]);
    out_data_nxt.rot_10  = qrm_sat(t[TXY] + t[TWZ]);
    out_data_nxt.rot_11  = qrm_sat(Q_ONE - (t[TXX] + t[TZZ]));
    out_data_nxt.rot_12  = qrm_sat(t[TYZ] - t[TWX]);
    out_data_nxt.rot_20  = qrm_sat(t[TXZ] - t[TWY]);
    out_data_nxt.rot_21  = qrm_sat(t[TYZ] + t[TWX]);
    out_data_nxt.rot_22  = qrm_sat(Q_ONE - (t[TXX] + t[TYY]));
    out_data_nxt.trans_x = in_data.tx;
    out_data_nxt.trans_y = in_data.ty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a cross term never exceeds half scale, since |ab| <= n/2
  `QRM_ASSERT_IMPL(a_cross_bound, clk, rst_n, in_valid && !in_data.zero, in_data.lane[TXY].quo <= HALF_SCALE && in_data.lane[TWZ].quo <= HALF_SCALE)
  // the three squared terms together stay within twice the one-constant
  `QRM_ASSERT_IMPL(a_diag_bound, clk, rst_n, in_valid && !in_data.zero, (QW+2)'(in_data.lane[TXX].quo) + (QW+2)'(in_data.lane[TYY].quo) + (QW+2)'(in_data.lane[TZZ].quo) <= (QW+2)'(32768))
  // a zero quaternion comes out as the identity
  `QRM_ASSERT_NEXT(a_zero_identity, clk, rst_n, in_valid && in_ready && in_data.zero, out_data.rot_00 == Q_ONE[FW-1:0] && out_data.rot_01 == '0 && out_data.rot_22 == Q_ONE[FW-1:0])

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for quaternion_to_rotation_matrix: a directed table, then random traffic.
// Depends on qrm_pkg for the transfer types; carries its own fixed-point matrix predictor.
`timescale 1ns / 1ps

module testbench;
  import qrm_pkg::*;

  localparam int  N_ITEMS    = 1250;
  localparam int  CALM_ITEMS = 150;   // tail of the run with no idling
  localparam int  TAIL_WAIT  = 40;    // idle wait after the final drain
  localparam int  STALL_MAX  = 2000;  // cycles without any transfer
  localparam int  MAX_REPORT = 10;
  localparam longint ONE_Q14 = 16384;

  typedef struct {
    qrm_in_t  stim;
    bit       known;
    qrm_out_t mat;
  } dir_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  qrm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  qrm_out_t out_data;

  qrm_out_t next_mat  = '0;  // expectation for the transfer being offered
  qrm_out_t pending_mats[$];
  dir_row_t dir_tab[$];
  int       bad_cnt   = 0;
  int       stall_cnt = 0;
  bit       calm      = 1'b0;

  string fld_name[11] = '{"rot_00", "rot_01", "rot_02", "rot_10", "rot_11", "rot_12",
                          "rot_20", "rot_21", "rot_22", "trans_x", "trans_y"};

  quaternion_to_rotation_matrix DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Product term 2ab/n in Q2.14, truncated toward zero; zero norm gives zero
  function automatic longint ratio_term(longint a, longint b, longint n);
    if (n <= 0) begin
      return 0;
    end
    return (a * b * 32768) / n;
  endfunction

  function automatic logic signed [15:0] clamp_q14(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Matrix predicted for one quaternion and shift
  function automatic qrm_out_t rotation_of(qrm_in_t q);
    longint   x, y, z, w, n;
    longint   txx, tyy, tzz, txy, txz, tyz, twx, twy, twz;
    qrm_out_t m;
    x = longint'($signed(q.quat_x));
    y = longint'($signed(q.quat_y));
    z = longint'($signed(q.quat_z));
    w = longint'($signed(q.quat_w));
    n = x * x + y * y + z * z + w * w;
    txx = ratio_term(x, x, n);
    tyy = ratio_term(y, y, n);
    tzz = ratio_term(z, z, n);
    txy = ratio_term(x, y, n);
    txz = ratio_term(x, z, n);
    tyz = ratio_term(y, z, n);
    twx = ratio_term(w, x, n);
    twy = ratio_term(w, y, n);
    twz = ratio_term(w, z, n);
    m.rot_00  = clamp_q14(ONE_Q14 - (tyy + tzz));
    m.rot_01  = clamp_q14(txy - twz);
    m.rot_02  = clamp_q14(txz + twy);
    m.rot_10  = clamp_q14(txy + twz);
    m.rot_11  = clamp_q14(ONE_Q14 - (txx + tzz));
    m.rot_12  = clamp_q14(tyz - twx);
    m.rot_20  = clamp_q14(txz - twy);
    m.rot_21  = clamp_q14(tyz + twx);
    m.rot_22  = clamp_q14(ONE_Q14 - (txx + tyy));
    m.trans_x = q.shift_x;
    m.trans_y = q.shift_y;
    return m;
  endfunction

  function automatic qrm_in_t mk_in(int x, int y, int z, int w, int sx, int sy);
    qrm_in_t q;
    q.quat_x  = 16'(x);
    q.quat_y  = 16'(y);
    q.quat_z  = 16'(z);
    q.quat_w  = 16'(w);
    q.shift_x = 16'(sx);
    q.shift_y = 16'(sy);
    return q;
  endfunction

  // Diagonal matrix with zero off-diagonals, for rows that can be read off by hand
  function automatic qrm_out_t mk_diag(int d0, int d1, int d2, int sx, int sy);
    qrm_out_t m;
    m = '0;
    m.rot_00  = 16'(d0);
    m.rot_11  = 16'(d1);
    m.rot_22  = 16'(d2);
    m.trans_x = 16'(sx);
    m.trans_y = 16'(sy);
    return m;
  endfunction

  function automatic dir_row_t tab_row(qrm_in_t s, bit k, qrm_out_t m);
    dir_row_t r;
    r.stim  = s;
    r.known = k;
    r.mat   = m;
    return r;
  endfunction

  function automatic int rand_s16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Random quaternion: mostly full range, plus small, sparse, extreme, near-unit and zero
  function automatic qrm_in_t rand_item();
    int c[4];
    int ext[7];
    int kind;
    ext  = '{-32768, 32767, 0, 1, -1, 16384, -16384};
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        5: c[i] = $urandom_range(0, 16) - 8;
        6: c[i] = ($urandom_range(0, 1) == 0) ? 0 : rand_s16();
        7: c[i] = ext[$urandom_range(0, 6)];
        8: c[i] = (i == 3) ? 16384 + $urandom_range(0, 512) - 256
                           : $urandom_range(0, 512) - 256;
        9: c[i] = 0;
        default: c[i] = rand_s16();
      endcase
    end
    return mk_in(c[0], c[1], c[2], c[3], rand_s16(), rand_s16());
  endfunction

  // Offer one transfer, optionally after an idle burst, and wait for it to be taken
  task automatic push_item(qrm_in_t s, qrm_out_t m, bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_data  <= s;
    next_mat <= m;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the input side until every outstanding matrix has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_mats.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    qrm_out_t want;
    bit       idle_on;

    // zero quaternion, unit axes at the extremes, mixed and truncating cases
    dir_tab.push_back(tab_row(mk_in(0, 0, 0, 0, 32767, -32768), 1,
                              mk_diag(16384, 16384, 16384, 32767, -32768)));
    dir_tab.push_back(tab_row(mk_in(16384, 0, 0, 0, 21845, -21846), 1,
                              mk_diag(16384, -16384, -16384, 21845, -21846)));
    dir_tab.push_back(tab_row(mk_in(0, 0, 0, 16384, 0, 0), 1,
                              mk_diag(16384, 16384, 16384, 0, 0)));
    dir_tab.push_back(tab_row(mk_in(0, 0, 0, -32768, -1, 0), 1,
                              mk_diag(16384, 16384, 16384, -1, 0)));
    dir_tab.push_back(tab_row(mk_in(-32768, 0, 0, 0, 0, -1), 1,
                              mk_diag(16384, -16384, -16384, 0, -1)));
    dir_tab.push_back(tab_row(mk_in(0, 32767, 0, 0, 1, 1), 1,
                              mk_diag(-16384, 16384, -16384, 1, 1)));
    dir_tab.push_back(tab_row(mk_in(0, 0, -32768, 0, -32768, 32767), 1,
                              mk_diag(-16384, -16384, 16384, -32768, 32767)));
    dir_tab.push_back(tab_row(mk_in(-1, 0, 0, 0, 0, 0), 1,
                              mk_diag(16384, -16384, -16384, 0, 0)));
    dir_tab.push_back(tab_row(mk_in(0, 0, 0, 0, 0, 0), 1,
                              mk_diag(16384, 16384, 16384, 0, 0)));
    dir_tab.push_back(tab_row(mk_in(-32768, -32768, -32768, -32768, 100, -100), 0, '0));
    dir_tab.push_back(tab_row(mk_in(32767, 32767, 32767, 32767, 0, 0), 0, '0));
    dir_tab.push_back(tab_row(mk_in(32767, -32768, 32767, -32768, 5, 6), 0, '0));
    dir_tab.push_back(tab_row(mk_in(1, 1, 1, 1, 0, 0), 0, '0));
    dir_tab.push_back(tab_row(mk_in(1, -1, 0, 0, 0, 0), 0, '0));
    dir_tab.push_back(tab_row(mk_in(1, 0, 0, 1, 0, 0), 0, '0));
    dir_tab.push_back(tab_row(mk_in(3, 5, 7, 11, 0, 0), 0, '0));
    dir_tab.push_back(tab_row(mk_in(1, 2, 3, 4, 0, 0), 0, '0));
    dir_tab.push_back(tab_row(mk_in(-7, 9, -11, 13, 0, 0), 0, '0));
    dir_tab.push_back(tab_row(mk_in(32767, -32768, 1, -1, 0, 0), 0, '0));
    dir_tab.push_back(tab_row(mk_in(12345, -23456, 5432, -777, 1234, -4321), 0, '0));
    dir_tab.push_back(tab_row(mk_in(16384, 16384, 0, 0, 0, 0), 0, '0));
    dir_tab.push_back(tab_row(mk_in(0, 0, -16384, -16384, 0, 0), 0, '0));
    dir_tab.push_back(tab_row(mk_in(-16384, 16384, -16384, 16384, 0, 0), 0, '0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      want = dir_tab[i].known ? dir_tab[i].mat : rotation_of(dir_tab[i].stim);
      push_item(dir_tab[i].stim, want, 1'b1);
    end
    drain();

    // random traffic; idling switches on and off in stretches, none in the tail
    for (int k = 0; k < N_ITEMS; k++) begin
      qrm_in_t s;
      if (k == N_ITEMS / 3 || k == 2 * N_ITEMS / 3) begin
        drain();
      end
      if (k == N_ITEMS - CALM_ITEMS) begin
        calm = 1'b1;
      end
      idle_on = !calm && ((k / 60) % 2 == 0);
      s = rand_item();
      push_item(s, rotation_of(s), idle_on);
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (bad_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side back-pressure: ready runs broken by stall bursts until the calm tail
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 40)) @(posedge clk);
        if (!calm) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
      end
    end
  end

  // Record accepted inputs and check every result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    qrm_out_t         want;
    logic [10:0][15:0] want_f;
    logic [10:0][15:0] got_f;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_mats.push_back(next_mat);
      end
      if (out_valid && out_ready) begin
        if (pending_mats.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= MAX_REPORT) begin
            $display("unexpected result transfer: %h", out_data);
          end
        end else begin
          want   = pending_mats.pop_front();
          want_f = want;
          got_f  = out_data;
          for (int i = 0; i < 11; i++) begin
            if (got_f[10-i] !== want_f[10-i]) begin
              bad_cnt++;
              if (bad_cnt <= MAX_REPORT) begin
                $display("%s mismatch: expected %0d, got %0d", fld_name[i],
                         $signed(want_f[10-i]), $signed(got_f[10-i]));
              end
            end
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
